// File: hw/rtl/ttlkv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TTL key/value table package
// Field widths, operation and status codes, and the stored entry layout.
// ----------------------------------------------------------------------------
package ttlkv_pkg;

    localparam int OP_W     = 3;
    localparam int KEY_W    = 64;
    localparam int VAL_W    = 64;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 2;
    localparam int TTL_W    = 33;
    localparam int COUNT_W  = 5;

    localparam logic [OP_W-1:0] OP_SET   = 3'd0;
    localparam logic [OP_W-1:0] OP_GET   = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL   = 3'd2;
    localparam logic [OP_W-1:0] OP_TTL   = 3'd3;
    localparam logic [OP_W-1:0] OP_PURGE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    localparam logic signed [TTL_W-1:0] TTL_MISSING = -33'sd2;
    localparam logic signed [TTL_W-1:0] TTL_NEVER   = -33'sd1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [TIME_W-1:0]  expiry;
    } t_tag;

endpackage
`default_nettype wire

// File: hw/rtl/ttlkv_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TTL key/value table request channel
// Valid/ready channel that carries one table request per transfer.
// ----------------------------------------------------------------------------
interface ttlkv_req_if;
    logic                          valid;
    logic                          ready;
    logic [ttlkv_pkg::OP_W-1:0]    op;
    logic [ttlkv_pkg::KEY_W-1:0]   key;
    logic [ttlkv_pkg::VAL_W-1:0]   value;
    logic [ttlkv_pkg::TIME_W-1:0]  expire_at;
    logic [ttlkv_pkg::TIME_W-1:0]  now;

    modport source (output valid, op, key, value, expire_at, now, input ready);
    modport sink   (input valid, op, key, value, expire_at, now, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/ttlkv_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TTL key/value table response channel
// Valid/ready channel that carries one table response per transfer.
// ----------------------------------------------------------------------------
interface ttlkv_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [ttlkv_pkg::STATUS_W-1:0]       status;
    logic [ttlkv_pkg::VAL_W-1:0]          value_out;
    logic signed [ttlkv_pkg::TTL_W-1:0]   ttl_out;
    logic [ttlkv_pkg::COUNT_W-1:0]        removed_count;

    modport source (output valid, status, value_out, ttl_out, removed_count, input ready);
    modport sink   (input valid, status, value_out, ttl_out, removed_count, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/ttlkv_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TTL key/value table RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module ttlkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AddrW-1:0] i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AddrW-1:0] i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: hw/rtl/ttl_key_value_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TTL key/value table
// Fixed-capacity key/value table with per-entry expiry, held in two RAMs.
// ----------------------------------------------------------------------------
// Requests arrive on i_req and one response per request leaves on o_rsp; both
// are valid/ready channels and a transfer happens when valid and ready are
// both high. Entries live in a tag RAM (valid, key, expiry) and a value RAM.
// Every request sweeps the RAMs one entry per cycle through the single read
// port: it finds the matching entry and the lowest free entry, and a purge
// clears expired entries as it passes them. The act state then applies the
// update and loads the response register. No new request is taken until the
// current one has left the act state. After reset the block clears the
// valid bits of the tag RAM with i_req.ready low. The response register
// lets the next request be taken while a response waits; if the receiver
// stalls longer, the finished request holds its update until the register
// is free.
// ----------------------------------------------------------------------------
module ttl_key_value_table_unit #(
    parameter int CAPACITY = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ttlkv_req_if.sink   i_req,
    ttlkv_rsp_if.source o_rsp
);

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CntW  = $clog2(CAPACITY + 1);
    localparam int TagW  = $bits(ttlkv_pkg::t_tag);
    localparam logic [AW-1:0]   LastIdx = AW'(CAPACITY - 1);
    localparam logic [CntW-1:0] Depth   = CntW'(CAPACITY);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SWEEP = 4'b0100,
        S_ACT   = 4'b1000
    } t_state;

    t_state r_state;

    logic [ttlkv_pkg::OP_W-1:0]   r_op;
    logic [ttlkv_pkg::KEY_W-1:0]  r_key;
    logic [ttlkv_pkg::VAL_W-1:0]  r_value;
    logic [ttlkv_pkg::TIME_W-1:0] r_expire_at;
    logic [ttlkv_pkg::TIME_W-1:0] r_now;

    logic [CntW-1:0] r_issue;
    logic            r_pend;
    logic [AW-1:0]   r_pend_idx;

    logic                         r_hit;
    logic [AW-1:0]                r_hit_idx;
    logic [ttlkv_pkg::TIME_W-1:0] r_hit_exp;
    logic [ttlkv_pkg::VAL_W-1:0]  r_hit_val;
    logic                         r_free;
    logic [AW-1:0]                r_free_idx;
    logic [ttlkv_pkg::COUNT_W-1:0] r_removed;

    logic                                r_out_valid;
    logic [ttlkv_pkg::STATUS_W-1:0]      r_out_status;
    logic [ttlkv_pkg::VAL_W-1:0]         r_out_value;
    logic signed [ttlkv_pkg::TTL_W-1:0]  r_out_ttl;
    logic [ttlkv_pkg::COUNT_W-1:0]       r_out_removed;

    ttlkv_pkg::t_tag              tag_rdata;
    logic [TagW-1:0]              tag_rbits;
    logic [ttlkv_pkg::VAL_W-1:0]  val_rdata;

    logic            tag_we;
    logic [AW-1:0]   tag_waddr;
    ttlkv_pkg::t_tag tag_wdata;
    logic            val_we;

    logic in_xfer;
    logic out_free;
    logic act_fire;
    logic scan_match;
    logic scan_expired;
    logic scan_purge;
    logic hit_expired;

    logic                                act_tag_we;
    logic [AW-1:0]                       act_idx;
    logic                                act_valid;
    logic                                act_val_we;
    logic [ttlkv_pkg::STATUS_W-1:0]      res_status;
    logic [ttlkv_pkg::VAL_W-1:0]         res_value;
    logic signed [ttlkv_pkg::TTL_W-1:0]  res_ttl;
    logic [ttlkv_pkg::COUNT_W-1:0]       res_removed;

    assign tag_rdata = ttlkv_pkg::t_tag'(tag_rbits);

    assign i_req.ready = (r_state == S_IDLE);
    assign in_xfer     = i_req.valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign act_fire    = (r_state == S_ACT) && out_free;

    assign scan_match   = tag_rdata.valid && (tag_rdata.key == r_key);
    assign scan_expired = (tag_rdata.expiry != '0) && (r_now >= tag_rdata.expiry);
    assign scan_purge   = (r_state == S_SWEEP) && r_pend && (r_op == ttlkv_pkg::OP_PURGE)
                          && tag_rdata.valid && scan_expired;
    assign hit_expired  = (r_hit_exp != '0) && (r_now >= r_hit_exp);

    always_comb begin
        act_tag_we  = 1'b0;
        act_idx     = r_hit_idx;
        act_valid   = 1'b0;
        act_val_we  = 1'b0;
        res_status  = ttlkv_pkg::ST_OK;
        res_value   = '0;
        res_ttl     = '0;
        res_removed = '0;
        unique case (r_op)
            ttlkv_pkg::OP_SET: begin
                if (r_hit || r_free) begin
                    act_tag_we = 1'b1;
                    act_val_we = 1'b1;
                    act_valid  = 1'b1;
                    act_idx    = r_hit ? r_hit_idx : r_free_idx;
                end else begin
                    res_status = ttlkv_pkg::ST_FULL;
                end
            end
            ttlkv_pkg::OP_GET: begin
                if (!r_hit) begin
                    res_status = ttlkv_pkg::ST_NOT_FOUND;
                end else if (hit_expired) begin
                    act_tag_we = 1'b1;
                    res_status = ttlkv_pkg::ST_NOT_FOUND;
                end else begin
                    res_value = r_hit_val;
                end
            end
            ttlkv_pkg::OP_DEL: begin
                if (!r_hit) begin
                    res_status = ttlkv_pkg::ST_NOT_FOUND;
                end else begin
                    act_tag_we = 1'b1;
                end
            end
            ttlkv_pkg::OP_TTL: begin
                if (!r_hit) begin
                    res_status = ttlkv_pkg::ST_NOT_FOUND;
                    res_ttl    = ttlkv_pkg::TTL_MISSING;
                end else if (r_hit_exp == '0) begin
                    res_ttl = ttlkv_pkg::TTL_NEVER;
                end else if (hit_expired) begin
                    act_tag_we = 1'b1;
                    res_status = ttlkv_pkg::ST_NOT_FOUND;
                    res_ttl    = ttlkv_pkg::TTL_MISSING;
                end else begin
                    res_ttl = {1'b0, r_hit_exp - r_now};
                end
            end
            ttlkv_pkg::OP_PURGE: begin
                res_removed = r_removed;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        tag_we    = 1'b0;
        tag_waddr = r_issue[AW-1:0];
        tag_wdata = '0;
        val_we    = 1'b0;
        priority if (r_state == S_CLEAR) begin
            tag_we = 1'b1;
        end else if (scan_purge) begin
            tag_we           = 1'b1;
            tag_waddr        = r_pend_idx;
            tag_wdata        = tag_rdata;
            tag_wdata.valid  = 1'b0;
        end else if (act_fire && act_tag_we) begin
            tag_we           = 1'b1;
            tag_waddr        = act_idx;
            tag_wdata.valid  = act_valid;
            tag_wdata.key    = r_key;
            tag_wdata.expiry = act_valid ? r_expire_at : r_hit_exp;
            val_we           = act_val_we;
        end else begin
        end
    end

    ttlkv_ram #(
        .WIDTH (TagW),
        .DEPTH (CAPACITY)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (tag_wdata),
        .i_raddr (r_issue[AW-1:0]),
        .o_rdata (tag_rbits)
    );

    ttlkv_ram #(
        .WIDTH (ttlkv_pkg::VAL_W),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (tag_waddr),
        .i_wdata (r_value),
        .i_raddr (r_issue[AW-1:0]),
        .o_rdata (val_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_issue     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rsp.ready && !act_fire) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_issue <= r_issue + 1'b1;
                    if (r_issue[AW-1:0] == LastIdx) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        r_issue <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (r_issue < Depth) begin
                        r_pend     <= 1'b1;
                        r_pend_idx <= r_issue[AW-1:0];
                        r_issue    <= r_issue + 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend && (r_pend_idx == LastIdx)) begin
                        r_state <= S_ACT;
                    end
                end
                S_ACT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op        <= i_req.op;
            r_key       <= i_req.key;
            r_value     <= i_req.value;
            r_expire_at <= i_req.expire_at;
            r_now       <= i_req.now;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_removed   <= '0;
        end else if ((r_state == S_SWEEP) && r_pend) begin
            if (scan_match && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_pend_idx;
                r_hit_exp <= tag_rdata.expiry;
                r_hit_val <= val_rdata;
            end
            if (!tag_rdata.valid && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_pend_idx;
            end
            if (scan_purge && (r_removed != ttlkv_pkg::COUNT_MAX)) begin
                r_removed <= r_removed + 1'b1;
            end
        end
        if (act_fire) begin
            r_out_status  <= res_status;
            r_out_value   <= res_value;
            r_out_ttl     <= res_ttl;
            r_out_removed <= res_removed;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.value_out     = r_out_value;
    assign o_rsp.ttl_out       = r_out_ttl;
    assign o_rsp.removed_count = r_out_removed;

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TTL key/value table testbench
// Sends table requests over the request channel, keeps a shadow copy of the
// table to work out the response each request must produce, and checks every
// response transfer field by field in order. Directed tests cover the empty
// table, every operation, expiry, overwrite, a full table and purge. Random
// traffic follows, with idle and stall bursts and one long response stall.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TABLE_SIZE      = 16;
    localparam int KEY_POOL_SIZE   = 22;
    localparam int PHASE_COUNT     = 6;
    localparam int PHASE_ITEMS     = 230;
    localparam int HALF_PERIOD     = 5;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int DRAIN_CYCLES    = TABLE_SIZE + 12;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_REPORTS     = 40;

    localparam logic [ttlkv_pkg::OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [ttlkv_pkg::OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic [ttlkv_pkg::STATUS_W-1:0]     status;
        logic [ttlkv_pkg::VAL_W-1:0]        value_out;
        logic signed [ttlkv_pkg::TTL_W-1:0] ttl_out;
        logic [ttlkv_pkg::COUNT_W-1:0]      removed_count;
    } t_kv_response;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ttlkv_req_if req_if ();
    ttlkv_rsp_if rsp_if ();

    ttl_key_value_table_unit #(.CAPACITY(TABLE_SIZE)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    logic                         shadow_valid  [TABLE_SIZE];
    logic [ttlkv_pkg::KEY_W-1:0]  shadow_key    [TABLE_SIZE];
    logic [ttlkv_pkg::VAL_W-1:0]  shadow_value  [TABLE_SIZE];
    logic [ttlkv_pkg::TIME_W-1:0] shadow_expiry [TABLE_SIZE];

    t_kv_response                 pending_responses [$];
    logic [ttlkv_pkg::KEY_W-1:0]  key_pool [KEY_POOL_SIZE];
    logic [ttlkv_pkg::TIME_W-1:0] wall_now;

    int unsigned cycle_count      = 0;
    int unsigned mismatch_count   = 0;
    int unsigned requests_sent    = 0;
    int unsigned responses_seen   = 0;
    int unsigned full_results     = 0;
    int unsigned expired_removals = 0;
    int unsigned rsp_stall_left   = 0;
    bit          idling_on        = 1'b1;
    bit          rsp_hold_off     = 1'b0;
    event        hold_off_start;

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < MAX_REPORTS) begin
            $display("%0t: mismatch on %s in response %0d: got %h, expected %h",
                     $time, what, responses_seen, got, want);
        end
        mismatch_count++;
    endtask

    // Applies one request to the shadow table and returns its response.
    function automatic t_kv_response predict_response(
        input logic [ttlkv_pkg::OP_W-1:0]   op,
        input logic [ttlkv_pkg::KEY_W-1:0]  key,
        input logic [ttlkv_pkg::VAL_W-1:0]  value,
        input logic [ttlkv_pkg::TIME_W-1:0] expire_at,
        input logic [ttlkv_pkg::TIME_W-1:0] now
    );
        t_kv_response rsp;
        int hit;
        int slot;
        int i;
        rsp = '0;
        hit = -1;
        for (i = 0; i < TABLE_SIZE; i++) begin
            if (hit < 0 && shadow_valid[i] && shadow_key[i] == key) hit = i;
        end
        case (op)
            ttlkv_pkg::OP_SET: begin
                slot = hit;
                for (i = 0; i < TABLE_SIZE; i++) begin
                    if (slot < 0 && !shadow_valid[i]) slot = i;
                end
                if (slot < 0) begin
                    rsp.status = ttlkv_pkg::ST_FULL;
                    full_results++;
                end else begin
                    shadow_valid[slot]  = 1'b1;
                    shadow_key[slot]    = key;
                    shadow_value[slot]  = value;
                    shadow_expiry[slot] = expire_at;
                end
            end
            ttlkv_pkg::OP_GET: begin
                if (hit < 0) begin
                    rsp.status = ttlkv_pkg::ST_NOT_FOUND;
                end else if (shadow_expiry[hit] != 0 && now >= shadow_expiry[hit]) begin
                    shadow_valid[hit] = 1'b0;
                    rsp.status = ttlkv_pkg::ST_NOT_FOUND;
                    expired_removals++;
                end else begin
                    rsp.value_out = shadow_value[hit];
                end
            end
            ttlkv_pkg::OP_DEL: begin
                if (hit < 0) rsp.status = ttlkv_pkg::ST_NOT_FOUND;
                else shadow_valid[hit] = 1'b0;
            end
            ttlkv_pkg::OP_TTL: begin
                if (hit < 0) begin
                    rsp.status  = ttlkv_pkg::ST_NOT_FOUND;
                    rsp.ttl_out = ttlkv_pkg::TTL_MISSING;
                end else if (shadow_expiry[hit] == 0) begin
                    rsp.ttl_out = ttlkv_pkg::TTL_NEVER;
                end else if (now >= shadow_expiry[hit]) begin
                    shadow_valid[hit] = 1'b0;
                    rsp.status  = ttlkv_pkg::ST_NOT_FOUND;
                    rsp.ttl_out = ttlkv_pkg::TTL_MISSING;
                    expired_removals++;
                end else begin
                    rsp.ttl_out = {1'b0, shadow_expiry[hit] - now};
                end
            end
            ttlkv_pkg::OP_PURGE: begin
                for (i = 0; i < TABLE_SIZE; i++) begin
                    if (shadow_valid[i] && shadow_expiry[i] != 0
                        && now >= shadow_expiry[i]) begin
                        shadow_valid[i] = 1'b0;
                        expired_removals++;
                        if (rsp.removed_count != ttlkv_pkg::COUNT_MAX) begin
                            rsp.removed_count++;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    // Called and returns at a falling edge; valid stays high on return.
    task automatic send_request(input logic [ttlkv_pkg::OP_W-1:0] op,
                                input logic [ttlkv_pkg::KEY_W-1:0] key,
                                input logic [ttlkv_pkg::VAL_W-1:0] value,
                                input logic [ttlkv_pkg::TIME_W-1:0] expire_at,
                                input logic [ttlkv_pkg::TIME_W-1:0] now);
        int gap;
        if (idling_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 11);
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.op        <= op;
        req_if.key       <= key;
        req_if.value     <= value;
        req_if.expire_at <= expire_at;
        req_if.now       <= now;
        do @(posedge i_clk); while (!req_if.ready);
        pending_responses.push_back(predict_response(op, key, value, expire_at, now));
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random_request();
        logic [ttlkv_pkg::OP_W-1:0]   op;
        logic [ttlkv_pkg::KEY_W-1:0]  key;
        logic [ttlkv_pkg::TIME_W-1:0] now;
        logic [ttlkv_pkg::TIME_W-1:0] expire_at;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 36) op = ttlkv_pkg::OP_SET;
        else if (pick < 56) op = ttlkv_pkg::OP_GET;
        else if (pick < 68) op = ttlkv_pkg::OP_DEL;
        else if (pick < 88) op = ttlkv_pkg::OP_TTL;
        else if (pick < 96) op = ttlkv_pkg::OP_PURGE;
        else op = ttlkv_pkg::OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        if (op != ttlkv_pkg::OP_SET && $urandom_range(0, 6) == 0) key = random_word();
        wall_now = wall_now + $urandom_range(0, 3);
        now = ($urandom_range(0, 24) == 0) ? $urandom : wall_now;
        pick = $urandom_range(0, 19);
        if (pick < 5) expire_at = '0;
        else if (pick < 15) expire_at = now + $urandom_range(1, 40);
        else if (pick < 18) expire_at = now - $urandom_range(0, 5);
        else expire_at = $urandom;
        send_request(op, key, random_word(), expire_at, now);
    endtask

    task automatic drain_responses();
        req_if.valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_empty_table();
        send_request(ttlkv_pkg::OP_GET, '0, '0, '0, '0);
        send_request(ttlkv_pkg::OP_TTL, '1, '0, '0, '0);
        send_request(ttlkv_pkg::OP_DEL, '0, '1, '1, '1);
        send_request(ttlkv_pkg::OP_PURGE, '0, '0, '0, '1);
    endtask

    task automatic test_basic_operations();
        logic [ttlkv_pkg::KEY_W-1:0] key_a;
        logic [ttlkv_pkg::KEY_W-1:0] key_b;
        key_a = random_word();
        key_b = ~key_a;
        send_request(ttlkv_pkg::OP_SET, '0, '1, '0, '0);
        send_request(ttlkv_pkg::OP_SET, '1, '0, '1, '0);
        send_request(ttlkv_pkg::OP_GET, '0, '0, '0, '1);
        send_request(ttlkv_pkg::OP_TTL, '0, '0, '0, '0);
        send_request(ttlkv_pkg::OP_TTL, '1, '0, '0, '0);
        send_request(ttlkv_pkg::OP_TTL, '1, '0, '0, 32'hFFFF_FFFE);
        send_request(ttlkv_pkg::OP_GET, '1, '0, '0, '1);
        send_request(ttlkv_pkg::OP_SET, key_a, random_word(), 32'd50, 32'd10);
        send_request(ttlkv_pkg::OP_TTL, key_a, '0, '0, 32'd60);
        send_request(ttlkv_pkg::OP_GET, key_a, '0, '0, 32'd60);
        send_request(ttlkv_pkg::OP_SET, key_b, random_word(), 32'd20, 32'd0);
        send_request(ttlkv_pkg::OP_SET, key_b, random_word(), 32'd0, 32'd30);
        send_request(ttlkv_pkg::OP_GET, key_b, '0, '0, 32'd40);
        send_request(ttlkv_pkg::OP_DEL, key_b, '0, '0, 32'd40);
        send_request(ttlkv_pkg::OP_DEL, key_b, '0, '0, 32'd40);
        for (int k = OP_UNUSED_FIRST; k <= OP_UNUSED_LAST; k++) begin
            send_request(k[ttlkv_pkg::OP_W-1:0], random_word(), random_word(), $urandom,
                         $urandom);
        end
    endtask

    task automatic test_full_table();
        for (int k = 0; k <= TABLE_SIZE; k++) begin
            send_request(ttlkv_pkg::OP_SET, 64'h1000 + k, random_word(),
                         (k == 3) ? 32'd0 : 32'd100, 32'd50);
        end
        send_request(ttlkv_pkg::OP_SET, 64'h1003, random_word(), 32'd100, 32'd60);
        send_request(ttlkv_pkg::OP_PURGE, '0, '0, '0, 32'd200);
        send_request(ttlkv_pkg::OP_DEL, '0, '0, '0, 32'd200);
        send_request(ttlkv_pkg::OP_GET, 64'h1000, '0, '0, 32'd200);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase != 0) begin
                for (int k = 0; k < KEY_POOL_SIZE; k++) begin
                    send_request(ttlkv_pkg::OP_DEL, key_pool[k], random_word(), $urandom,
                                 wall_now);
                end
            end
            for (int k = 0; k < KEY_POOL_SIZE; k++) key_pool[k] = random_word();
            case (phase)
                0: wall_now = '0;
                1: wall_now = 32'hFFFF_FF80;
                2: wall_now = 32'h8000_0000;
                default: wall_now = $urandom;
            endcase
            idling_on = (phase != 3);
            for (int n = 0; n < PHASE_ITEMS; n++) send_random_request();
        end
        idling_on = 1'b1;
    endtask

    task automatic test_backpressure();
        -> hold_off_start;
        for (int n = 0; n < 40; n++) send_random_request();
    endtask

    task automatic test_unpaced_traffic();
        idling_on = 1'b0;
        for (int n = 0; n < 250; n++) send_random_request();
    endtask

    always @(negedge i_clk) begin
        if (rsp_hold_off) begin
            rsp_if.ready <= 1'b0;
        end else if (rsp_stall_left != 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall_left <= rsp_stall_left - 1;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall_left <= $urandom_range(0, 10);
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    initial begin
        forever begin
            @(hold_off_start);
            rsp_hold_off = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            rsp_hold_off = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_kv_response want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            responses_seen++;
            if (pending_responses.size() == 0) begin
                report_mismatch("unrequested transfer", rsp_if.value_out, '0);
            end else begin
                want = pending_responses.pop_front();
                if (rsp_if.status !== want.status) begin
                    report_mismatch("status", rsp_if.status, want.status);
                end
                if (rsp_if.value_out !== want.value_out) begin
                    report_mismatch("value_out", rsp_if.value_out, want.value_out);
                end
                if (rsp_if.ttl_out !== want.ttl_out) begin
                    report_mismatch("ttl_out", rsp_if.ttl_out, want.ttl_out);
                end
                if (rsp_if.removed_count !== want.removed_count) begin
                    report_mismatch("removed_count", rsp_if.removed_count,
                                    want.removed_count);
                end
            end
        end
    end

    initial begin
        req_if.valid     <= 1'b0;
        req_if.op        <= ttlkv_pkg::OP_SET;
        req_if.key       <= '0;
        req_if.value     <= '0;
        req_if.expire_at <= '0;
        req_if.now       <= '0;
        i_rst_n          <= 1'b0;
        wall_now = '0;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            shadow_valid[i]  = 1'b0;
            shadow_key[i]    = '0;
            shadow_value[i]  = '0;
            shadow_expiry[i] = '0;
        end
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_basic_operations();
        test_full_table();
        test_random_traffic();
        test_backpressure();
        test_unpaced_traffic();
        drain_responses();

        $display("Checked %0d responses to %0d requests; %0d hit a full table, %0d expired",
                 responses_seen, requests_sent, full_results, expired_removals);
        $display("entries were removed, across time wrap-around and a long response stall.");
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/ttlkv_pkg.sv
hw/rtl/ttlkv_req_if.sv
hw/rtl/ttlkv_rsp_if.sv
hw/rtl/ttlkv_ram.sv
hw/rtl/ttl_key_value_table_unit.sv
tb/sv/testbench.sv
